// ===== sv/sdad_pkg.sv =====
// Shared types, constants and delta tables for the SND1 delta audio decoder.
package sdad_pkg;

   localparam int DATA_W    = 8;
   localparam int LEN_W     = 16;
   localparam int REQ_TDATA_W = 40;   // byte + two 16-bit lengths, already whole bytes
   localparam int RSP_TDATA_W = 8;
   localparam int STEP_W    = 6;      // up to 64 samples per byte
   localparam int RUN_W     = 7;      // run counts 1..64
   localparam int DELTA_W   = 5;
   localparam int SUM_W     = 10;

   localparam logic [DATA_W-1:0] PRED_RESET = 8'h80;

   // Header byte modes (top two bits)
   localparam logic [1:0] MODE_TWO_BIT    = 2'd0;
   localparam logic [1:0] MODE_FOUR_BIT   = 2'd1;
   localparam logic [1:0] MODE_DELTA_COPY = 2'd2;
   localparam logic [1:0] MODE_REPEAT     = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;   // input beat taken this cycle
      logic emit;     // produce one sample into the output register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic has_samples;  // the beat being offered yields at least one sample
      logic final_step;   // the sample about to be emitted ends this byte
      logic slot_free;    // output register can take a sample
   } stat_type;

   // 2-bit delta table
   function automatic logic signed [DELTA_W-1:0] two_delta(input logic [1:0] idx);
      logic signed [DELTA_W-1:0] d;
      case (idx)
         2'd0:    d = -5'sd2;
         2'd1:    d = -5'sd1;
         2'd2:    d = 5'sd0;
         default: d = 5'sd1;
      endcase
      return d;
   endfunction

   // 4-bit delta table
   function automatic logic signed [DELTA_W-1:0] four_delta(input logic [3:0] idx);
      logic signed [DELTA_W-1:0] d;
      case (idx)
         4'd0:    d = -5'sd9;
         4'd1:    d = -5'sd8;
         4'd2:    d = -5'sd6;
         4'd3:    d = -5'sd5;
         4'd4:    d = -5'sd4;
         4'd5:    d = -5'sd3;
         4'd6:    d = -5'sd2;
         4'd7:    d = -5'sd1;
         4'd8:    d = 5'sd0;
         4'd9:    d = 5'sd1;
         4'd10:   d = 5'sd2;
         4'd11:   d = 5'sd3;
         4'd12:   d = 5'sd4;
         4'd13:   d = 5'sd5;
         4'd14:   d = 5'sd6;
         default: d = 5'sd8;
      endcase
      return d;
   endfunction

endpackage

// ===== sv/sdad_ctrl.sv =====
// Controller: takes input beats and sequences the samples of each byte.
module sdad_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sdad_pkg::stat_type stat,
   output sdad_pkg::cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && stat.has_samples) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cmd.emit && stat.final_step) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands
   assign req_tready = (state_ff == ST_IDLE);
   assign cmd.accept = req_tvalid && req_tready;
   assign cmd.emit   = (state_ff == ST_RUN) && stat.slot_free;

   // A byte that yields samples holds off the next beat
   a_hold_after_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && stat.has_samples) |=> !req_tready)
      else $error("input taken while samples of previous byte pending");

endmodule

// ===== sv/sdad_dp.sv =====
// Datapath: chunk budgets, run state, predictor, sample arithmetic, output register.
module sdad_dp #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sdad_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_chunk_start,
   input  sdad_pkg::cmd_type                   cmd,
   output sdad_pkg::stat_type                  stat,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [sdad_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int DW = sdad_pkg::DATA_W;
   localparam int LW = sdad_pkg::LEN_W;
   localparam int CW = (LENGTH_BITS < LW) ? LENGTH_BITS : LW;

   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_TWO_BIT,
      KIND_FOUR_BIT,
      KIND_COPY
   } kind_type;

   typedef enum logic [2:0] {
      JOB_NONE,
      JOB_COPY,
      JOB_TWO,
      JOB_FOUR,
      JOB_DELTA,
      JOB_REPEAT
   } job_type;

   // State
   logic [DW-1:0]                  pred_ff, pred_in;
   kind_type                       kind_ff, kind_in;
   logic [sdad_pkg::RUN_W-1:0]     run_left_ff, run_left_in;
   logic [LENGTH_BITS-1:0]         in_left_ff, in_left_in;
   logic [LENGTH_BITS-1:0]         out_left_ff, out_left_in;
   logic                           pass_ff, pass_in;
   job_type                        job_ff, job_in;
   logic [DW-1:0]                  byte_ff, byte_in;
   logic [sdad_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [sdad_pkg::STEP_W-1:0]    step_last_ff, step_last_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                  rsp_data_ff, rsp_data_in;
   logic                           rsp_last_ff, rsp_last_in;

   // Input beat fields
   logic [DW-1:0]           in_byte;
   logic [LENGTH_BITS-1:0]  in_ilen, in_olen;
   assign in_byte = req_tdata[DW-1:0];
   assign in_ilen = LENGTH_BITS'(req_tdata[DW+CW-1:DW]);
   assign in_olen = LENGTH_BITS'(req_tdata[DW+LW+CW-1:DW+LW]);

   // State as seen by this beat, after an optional chunk reload
   logic [DW-1:0]               eff_pred;
   kind_type                    eff_kind;
   logic [sdad_pkg::RUN_W-1:0]  eff_run_left, dec_run_left;
   logic [LENGTH_BITS-1:0]      eff_in_left, eff_out_left;
   logic                        eff_pass, live;

   always_comb begin
      if (req_chunk_start) begin
         eff_pred     = sdad_pkg::PRED_RESET;
         eff_kind     = KIND_HEADER;
         eff_run_left = '0;
         eff_in_left  = in_ilen;
         eff_out_left = in_olen;
         eff_pass     = (in_ilen == in_olen);
      end else begin
         eff_pred     = pred_ff;
         eff_kind     = kind_ff;
         eff_run_left = run_left_ff;
         eff_in_left  = in_left_ff;
         eff_out_left = out_left_ff;
         eff_pass     = pass_ff;
      end
      live = (eff_in_left != '0) && (eff_out_left != '0);
      dec_run_left = (eff_run_left != '0) ? eff_run_left - 1'b1 : eff_run_left;
   end

   // Byte decode: job for the byte and the run state it leaves
   job_type                     dec_job;
   kind_type                    dec_kind;
   logic [sdad_pkg::RUN_W-1:0]  dec_run;
   logic [sdad_pkg::STEP_W-1:0] dec_last;
   logic [sdad_pkg::RUN_W-1:0]  hdr_count;
   assign hdr_count = {1'b0, in_byte[5:0]} + 1'b1;

   always_comb begin
      dec_job  = JOB_NONE;
      dec_kind = eff_kind;
      dec_run  = eff_run_left;
      dec_last = '0;
      if (eff_pass) begin
         dec_job = JOB_COPY;
      end else begin
         // data bytes of a run count the run down
         if (eff_kind != KIND_HEADER) begin
            dec_run  = dec_run_left;
            dec_kind = (dec_run_left == '0) ? KIND_HEADER : eff_kind;
         end
         case (eff_kind)
            KIND_TWO_BIT: begin
               dec_job  = JOB_TWO;
               dec_last = sdad_pkg::STEP_W'(3);
            end
            KIND_FOUR_BIT: begin
               dec_job  = JOB_FOUR;
               dec_last = sdad_pkg::STEP_W'(1);
            end
            KIND_COPY: dec_job = JOB_COPY;
            default: begin
               dec_kind = KIND_HEADER;
               dec_run  = '0;
               case (in_byte[7:6])
                  sdad_pkg::MODE_TWO_BIT: begin
                     dec_kind = KIND_TWO_BIT;
                     dec_run  = hdr_count;
                  end
                  sdad_pkg::MODE_FOUR_BIT: begin
                     dec_kind = KIND_FOUR_BIT;
                     dec_run  = hdr_count;
                  end
                  sdad_pkg::MODE_DELTA_COPY: begin
                     if (in_byte[5]) begin
                        dec_job = JOB_DELTA;
                     end else begin
                        dec_kind = KIND_COPY;
                        dec_run  = hdr_count;
                     end
                  end
                  default: begin
                     // repeat mode
                     dec_job  = JOB_REPEAT;
                     dec_last = in_byte[5:0];
                  end
               endcase
            end
         endcase
      end
   end

   // Sample arithmetic for the current step
   logic signed [sdad_pkg::DELTA_W-1:0] delta;
   logic signed [sdad_pkg::SUM_W-1:0]   sum;
   logic [DW-1:0]                       clamped, sample;
   logic [DW-1:0]                       two_shift;

   always_comb begin
      two_shift = byte_ff >> {step_ff[1:0], 1'b0};
      case (job_ff)
         JOB_TWO:   delta = sdad_pkg::two_delta(two_shift[1:0]);
         JOB_FOUR:  delta = sdad_pkg::four_delta(step_ff[0] ? byte_ff[7:4] : byte_ff[3:0]);
         JOB_DELTA: delta = byte_ff[4:0];
         default:   delta = '0;
      endcase
      sum = $signed({2'b00, pred_ff}) + sdad_pkg::SUM_W'(delta);
      if (sum[sdad_pkg::SUM_W-1])  clamped = '0;
      else if (sum[DW])            clamped = '1;
      else                         clamped = sum[DW-1:0];
      case (job_ff)
         JOB_COPY:   sample = byte_ff;
         JOB_REPEAT: sample = pred_ff;
         default:    sample = clamped;
      endcase
   end

   // Status
   assign stat.has_samples = live && (dec_job != JOB_NONE);
   assign stat.final_step  = (step_ff == step_last_ff) || (out_left_ff == LENGTH_BITS'(1));
   assign stat.slot_free   = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      pred_in      = pred_ff;
      kind_in      = kind_ff;
      run_left_in  = run_left_ff;
      in_left_in   = in_left_ff;
      out_left_in  = out_left_ff;
      pass_in      = pass_ff;
      job_in       = job_ff;
      byte_in      = byte_ff;
      step_in      = step_ff;
      step_last_in = step_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.accept) begin
         pred_in     = eff_pred;
         kind_in     = eff_kind;
         run_left_in = eff_run_left;
         in_left_in  = eff_in_left;
         out_left_in = eff_out_left;
         pass_in     = eff_pass;
         if (live) begin
            in_left_in   = eff_in_left - 1'b1;
            kind_in      = dec_kind;
            run_left_in  = dec_run;
            job_in       = dec_job;
            byte_in      = in_byte;
            step_in      = '0;
            step_last_in = dec_last;
         end
      end else if (cmd.emit) begin
         if (job_ff != JOB_REPEAT) pred_in = sample;
         out_left_in  = out_left_ff - 1'b1;
         step_in      = step_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_data_in  = sample;
         rsp_last_in  = stat.final_step;
         if (stat.final_step) step_in = '0;
      end
   end

   // Control state is reset; payload registers are not
   always_ff @(posedge clock) begin
      if (reset) begin
         pred_ff      <= sdad_pkg::PRED_RESET;
         kind_ff      <= KIND_HEADER;
         run_left_ff  <= '0;
         in_left_ff   <= '0;
         out_left_ff  <= '0;
         pass_ff      <= 1'b0;
         job_ff       <= JOB_NONE;
         step_ff      <= '0;
         step_last_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pred_ff      <= pred_in;
         kind_ff      <= kind_in;
         run_left_ff  <= run_left_in;
         in_left_ff   <= in_left_in;
         out_left_ff  <= out_left_in;
         pass_ff      <= pass_in;
         job_ff       <= job_in;
         step_ff      <= step_in;
         step_last_ff <= step_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.slot_free)
      else $error("sample emitted over an untaken result");

   a_budget: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (out_left_ff != '0))
      else $error("sample emitted past the chunk output length");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= step_last_ff)
      else $error("step counter ran past the last sample of the byte");

endmodule

// ===== sv/snd1_delta_audio_decoder.sv =====
// Top level of the SND1 delta audio decoder: controller plus datapath.
//
//  Channel   Dir  Ports                    Content
//  req       in   req_tdata / req_tuser    data_byte, chunk_in_len, chunk_out_len / chunk_start
//  rsp       out  rsp_tdata / rsp_tlast    sample / last_of_byte
//
// A byte is taken first and then yields its samples, one per cycle while the output
// register is free: header bytes none, copy and delta bytes one, 4-bit bytes two,
// 2-bit bytes four, repeat headers up to 64. A byte's samples all go out before the next beat.
// Reset (synchronous, active high) sets the predictor to 128 and clears the
// budgets. A stalled result holds the output register and pauses sample
// generation; the next beat is taken while the last sample still waits.
module snd1_delta_audio_decoder #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] data_byte, [23:8] chunk_in_len, [39:24] chunk_out_len
   input  logic [sdad_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] chunk_start
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] sample
   output logic [sdad_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast
);

   sdad_pkg::cmd_type  cmd;
   sdad_pkg::stat_type stat;

   sdad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sdad_dp #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_tdata       (req_tdata),
      .req_chunk_start (req_tuser[0]),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast)
   );

endmodule
